// ===== rtl/bitmr_pkg.sv =====
`default_nettype none
package bitmr_pkg;

  // Command codes carried in a request beat
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Byte map
  localparam int unsigned NUM_BYTES  = 8;
  localparam logic [2:0]  LATCH_BYTE = 3'd3;
  localparam logic [2:0]  MODE_BYTE  = 3'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] addr;
    logic [7:0] wdata;
  } req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       timer_irq;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/bitmr_core.sv =====
`default_nettype none
module bitmr_core #(
  parameter int unsigned PERIOD_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  bitmr_pkg::req_t     req,
  output bitmr_pkg::rsp_t     result
);
  import bitmr_pkg::*;

  logic [7:0]             regs [NUM_BYTES];
  logic [PERIOD_BITS-1:0] period;
  logic [PERIOD_BITS-1:0] period_next;
  logic [PERIOD_BITS-1:0] elapsed;
  logic [PERIOD_BITS-1:0] elapsed_next;
  logic [PERIOD_BITS-1:0] elapsed_inc;
  logic [31:0]            latch_word;
  logic                   armed;

  assign armed       = (period != '0);
  assign elapsed_inc = elapsed + {{(PERIOD_BITS-1){1'b0}}, 1'b1};
  // Period as it reads once the byte-3 write lands
  assign latch_word  = {req.wdata, regs[2], regs[1], regs[0]};

  // Result and next timer state for the beat being accepted
  always_comb begin
    result       = '0;
    period_next  = period;
    elapsed_next = elapsed;
    case (req.cmd)
      CMD_TICK: begin
        if (armed) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= period) begin
            result.timer_irq = 1'b1;
            elapsed_next     = '0;
            // one-shot mode: drop the period, which disarms
            if (regs[MODE_BYTE] != 8'd0) begin
              period_next = '0;
            end
          end
        end
      end
      CMD_READ: begin
        result.rdata = regs[req.addr];
      end
      CMD_WRITE: begin
        if (req.addr == LATCH_BYTE) begin
          period_next  = latch_word[PERIOD_BITS-1:0];
          elapsed_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Register file and timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BYTES; i++) begin
        regs[i] <= 8'd0;
      end
      period  <= '0;
      elapsed <= '0;
    end else if (fire) begin
      if (req.cmd == CMD_WRITE) begin
        regs[req.addr] <= req.wdata;
      end
      period  <= period_next;
      elapsed <= elapsed_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bitmr_obuf.sv =====
`default_nettype none
module bitmr_obuf (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  bitmr_pkg::rsp_t result,
  output logic            busy,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output bitmr_pkg::rsp_t rsp
);
  import bitmr_pkg::*;

  logic skid_valid;
  rsp_t skid;
  logic out_free;

  // Output register can take a beat when empty or being drained now
  assign out_free = !rsp_valid || !rsp_stall;
  assign busy     = skid_valid;

  // Control: output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        rsp_valid  <= skid_valid || fire;
        skid_valid <= skid_valid && fire;
      end else if (fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload: skid drains first to keep order
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        rsp <= skid;
        if (fire) begin
          skid <= result;
        end
      end else if (fire) begin
        rsp <= result;
      end
    end else if (fire) begin
      skid <= result;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bus_interval_timer_top.sv =====
`default_nettype none
// Interval timer behind eight byte registers. Bytes 0..3 are a little-endian
// period in tick units and byte 4 the mode (zero repeats, nonzero fires once);
// bytes 5..7 are scratch. A write to byte 3 loads the period and restarts the
// count. Every request beat (tick, read or write) yields exactly one response
// beat, with rdata holding the byte on a read and timer_irq set on the tick
// at which the period expires. With no response stall, one beat per cycle
// is sustained: each request is handled in the cycle it is taken, and the
// response goes out through an output register backed by a one-entry skid
// buffer, so a stalled response holds off requests only once it is full.
module bus_interval_timer_top #(
  parameter int unsigned PERIOD_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  bitmr_pkg::req_t req,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output bitmr_pkg::rsp_t rsp
);
  import bitmr_pkg::*;

  logic fire;
  logic busy;
  rsp_t result;

  assign req_stall = busy;
  assign fire      = req_valid && !busy;

  bitmr_core #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .req    (req),
    .result (result)
  );

  bitmr_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .result    (result),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/bitmr_checker.sv =====
`default_nettype none
module bitmr_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_stall,
  input wire bitmr_pkg::req_t req,
  input wire logic            rsp_valid,
  input wire logic            rsp_stall,
  input wire bitmr_pkg::rsp_t rsp
);
  import bitmr_pkg::*;

  // A response never carries both read data and an interrupt
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.timer_irq |-> rsp.rdata == 8'd0)
    else $error("irq beat with nonzero rdata");

  // Nothing is pending right after reset
  assert property (@(posedge clk) rst |=> !rsp_valid && !req_stall)
    else $error("output not empty after reset");

  // With the output empty the block always takes requests
  assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("stall while output empty");

  // Stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // A non-tick beat taken while the output is free never raises the interrupt
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.cmd != CMD_TICK && (!rsp_valid || !rsp_stall)
    |=> rsp_valid && !rsp.timer_irq)
    else $error("interrupt on a non-tick beat");

endmodule

bind bus_interval_timer_top bitmr_checker u_bitmr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire

// ===== tb/sv/tb_bus_interval_timer_top.sv =====
`default_nettype none
module tb_bus_interval_timer_top;
  import bitmr_pkg::*;

  localparam int unsigned PERIOD_BITS = 32;
  localparam logic [31:0] PERIOD_MASK =
    (PERIOD_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PERIOD_BITS) - 32'd1);
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TOTAL_BEATS = 2025;
  localparam int CALM_BEATS = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIR = 25;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  bus_interval_timer_top #(.PERIOD_BITS(PERIOD_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the timer state
  logic [7:0] reg_bytes [8] = '{default: 8'h00};
  logic [31:0] armed_period = '0;
  logic [31:0] tick_count = '0;

  rsp_t expected_rsp [$];
  int errors = 0;
  int beats_sent = 0;
  int rsp_seen = 0;
  int cycle_cnt = 0;
  bit calm = 1'b0;

  // Directed rows; has_want marks a response typed in by hand
  typedef struct packed {
    req_t beat;
    logic has_want;
    rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    '{'{CMD_READ,   3'd0, 8'h00}, 1'b1, '{8'h00, 1'b0}},  // reset value
    '{'{CMD_READ,   3'd7, 8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b1, '{8'h00, 1'b0}},  // disarmed
    '{'{CMD_UNUSED, 3'd5, 8'hFF}, 1'b1, '{8'h00, 1'b0}},  // unused command
    '{'{CMD_WRITE,  3'd7, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
    '{'{CMD_READ,   3'd7, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
    '{'{CMD_WRITE,  3'd0, 8'h02}, 1'b0, '0},
    '{'{CMD_WRITE,  3'd3, 8'h00}, 1'b0, '0},              // period 2, periodic
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b0, '0},
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b0, '0},
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{CMD_WRITE,  3'd4, 8'h01}, 1'b0, '0},              // switch to once
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b0, '0},
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b1, '{8'h00, 1'b0}},  // disarmed again
    '{'{CMD_READ,   3'd4, 8'h00}, 1'b1, '{8'h01, 1'b0}},
    '{'{CMD_WRITE,  3'd0, 8'hFF}, 1'b0, '0},              // max period
    '{'{CMD_WRITE,  3'd1, 8'hFF}, 1'b0, '0},
    '{'{CMD_WRITE,  3'd2, 8'hFF}, 1'b0, '0},
    '{'{CMD_WRITE,  3'd3, 8'hFF}, 1'b0, '0},
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b0, '0},
    '{'{CMD_READ,   3'd3, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
    '{'{CMD_WRITE,  3'd3, 8'hFF}, 1'b0, '0},              // same-value relatch
    '{'{CMD_TICK,   3'd0, 8'h00}, 1'b0, '0}
  };

  // Advance the shadow timer by one request beat
  function automatic rsp_t timer_step(req_t r);
    rsp_t o;
    o = '0;
    case (r.cmd)
      CMD_TICK: begin
        if (armed_period != 32'd0) begin
          tick_count = (tick_count + 32'd1) & PERIOD_MASK;
          if (tick_count >= armed_period) begin
            o.timer_irq = 1'b1;
            tick_count = '0;
            if (reg_bytes[MODE_BYTE] != 8'h00) armed_period = '0;
          end
        end
      end
      CMD_READ: o.rdata = reg_bytes[r.addr];
      CMD_WRITE: begin
        reg_bytes[r.addr] = r.wdata;
        if (r.addr == LATCH_BYTE) begin
          armed_period = {reg_bytes[3], reg_bytes[2], reg_bytes[1], reg_bytes[0]} &
                         PERIOD_MASK;
          tick_count = '0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Offer one beat, wait for it to be taken, then maybe go idle
  task automatic send_beat(req_t r, logic has_want, rsp_t want);
    rsp_t p;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    p = timer_step(r);
    expected_rsp.push_back(has_want ? want : p);
    beats_sent++;
    calm = (beats_sent > TOTAL_BEATS - CALM_BEATS);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    req_t r;
    logic [31:0] period;
    logic [7:0] mode;
    bit mode_first;
    int n_ticks;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++)
      send_beat(dir_rows[i].beat, dir_rows[i].has_want, dir_rows[i].want);

    while (beats_sent < TOTAL_BEATS) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise beat, any command
        r.cmd = 2'($urandom_range(0, 3));
        r.addr = 3'($urandom);
        r.wdata = 8'($urandom);
        send_beat(r, 1'b0, '0);
      end else begin
        // program a period, then run ticks with bus traffic mixed in
        case ($urandom_range(0, 9))
          0: period = '0;
          1: period = $urandom;
          default: period = 32'($urandom_range(1, 12));
        endcase
        mode = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        mode_first = $urandom_range(0, 1);
        if (mode_first) send_beat('{CMD_WRITE, MODE_BYTE, mode}, 1'b0, '0);
        for (int b = 0; b < 4; b++) begin
          // now and then a low byte goes missing
          if (b == 3 || $urandom_range(0, 15) != 0)
            send_beat('{CMD_WRITE, 3'(b), period[8*b +: 8]}, 1'b0, '0);
        end
        if (!mode_first) send_beat('{CMD_WRITE, MODE_BYTE, mode}, 1'b0, '0);
        n_ticks = $urandom_range(1, 40);
        for (int t = 0; t < n_ticks; t++) begin
          case ($urandom_range(0, 9))
            0: r = '{CMD_READ, 3'($urandom), 8'($urandom)};
            1: r = '{CMD_WRITE, 3'($urandom), 8'($urandom)};
            default: r = '{CMD_TICK, 3'($urandom), 8'($urandom)};
          endcase
          send_beat(r, 1'b0, '0);
        end
      end
    end
    req_valid <= 1'b0;

    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver stall: random bursts, one long hold-off, none near the end
  int hold_left = 0;
  int burst_left = 0;
  bit hold_done = 1'b0;
  initial rsp_stall = 1'b0;
  always @(posedge clk) begin
    if (!hold_done && rsp_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      rsp_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(0, 3);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Response check against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_seen++;
      if (expected_rsp.size() == 0) begin
        $error("response beat with nothing expected: rdata %0h timer_irq %0b",
               rsp.rdata, rsp.timer_irq);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.rdata !== want.rdata) begin
          $error("rdata: expected %0h, got %0h", want.rdata, rsp.rdata);
          errors++;
        end
        if (rsp.timer_irq !== want.timer_irq) begin
          $error("timer_irq: expected %0b, got %0b", want.timer_irq, rsp.timer_irq);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
`default_nettype wire
